### design/rlc_pkg.sv
`default_nettype none

package rlc_pkg;

	// Field widths
	localparam int LVL_W    = 8;
	localparam int Q_W      = 9;
	localparam int PERIOD_W = 16;
	localparam int ACT_W    = 2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SET   = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [LVL_W-1:0] red_in;
		logic [LVL_W-1:0] green_in;
		logic [LVL_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [LVL_W-1:0] red_out;
		logic [LVL_W-1:0] green_out;
		logic [LVL_W-1:0] blue_out;
		logic             fading;
		logic             finished;
	} out_item_t;

	// Per-item commands from the sequencer to the channel lanes
	typedef struct packed {
		logic en;
		logic start;
		logic set;
		logic step;
	} lane_ctl_t;

endpackage

`default_nettype wire

### design/rlc_lane.sv
`default_nettype none

module rlc_lane import rlc_pkg::*; #(
	parameter int NUM_STEPS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_ctl_t        ctl,
	input  logic [LVL_W-1:0] target,
	output logic [LVL_W-1:0] level_d
);

	localparam int RW = $clog2(NUM_STEPS + 1);
	localparam int NUM_ENT = 1 << LVL_W;

	typedef logic [LVL_W-1:0] quo_tab_t [NUM_ENT];
	typedef logic [RW-1:0]    rem_tab_t [NUM_ENT];

	function automatic quo_tab_t build_quo();
		quo_tab_t t;
		for (int i = 0; i < NUM_ENT; i++) begin
			t[i] = LVL_W'(i / NUM_STEPS);
		end
		return t;
	endfunction

	function automatic rem_tab_t build_rem();
		rem_tab_t t;
		for (int i = 0; i < NUM_ENT; i++) begin
			t[i] = RW'(i % NUM_STEPS);
		end
		return t;
	endfunction

	localparam quo_tab_t QUO_TAB = build_quo();
	localparam rem_tab_t REM_TAB = build_rem();

	logic        [LVL_W-1:0] level_q;
	logic signed [Q_W-1:0]   quo_q;
	logic        [RW-1:0]    rabs_q;
	logic                    neg_q;
	logic        [RW-1:0]    acc_q;

	logic signed [Q_W-1:0]   diff;
	logic                    dneg;
	logic        [LVL_W-1:0] dmag;
	logic signed [Q_W-1:0]   new_quo;
	logic        [RW-1:0]    new_rabs;

	logic signed [Q_W-1:0]   quo_e;
	logic        [RW-1:0]    rabs_e;
	logic                    neg_e;
	logic        [RW-1:0]    acc_e;
	logic        [RW:0]      sum;
	logic                    extra;
	logic        [RW-1:0]    acc_n;
	logic signed [Q_W-1:0]   adj;
	logic signed [Q_W-1:0]   delta;

	// Split the distance to the target into quotient and remainder by table
	always_comb begin
		diff     = $signed({1'b0, target}) - $signed({1'b0, level_q});
		dneg     = diff[Q_W-1];
		dmag     = dneg ? LVL_W'(-diff) : LVL_W'(diff);
		new_quo  = dneg ? -$signed({1'b0, QUO_TAB[dmag]}) : $signed({1'b0, QUO_TAB[dmag]});
		new_rabs = REM_TAB[dmag];
	end

	// Spread the remainder one unit per accumulator wrap; set, step or hold the level
	always_comb begin
		quo_e  = ctl.start ? new_quo  : quo_q;
		rabs_e = ctl.start ? new_rabs : rabs_q;
		neg_e  = ctl.start ? dneg     : neg_q;
		acc_e  = ctl.start ? '0       : acc_q;
		sum    = {1'b0, acc_e} + {1'b0, rabs_e};
		extra  = sum >= (RW+1)'(NUM_STEPS);
		acc_n  = extra ? RW'(sum - (RW+1)'(NUM_STEPS)) : sum[RW-1:0];
		adj    = '0;
		if (extra) begin
			adj = neg_e ? '1 : Q_W'(1);
		end
		delta  = quo_e + adj;
		if (ctl.set) begin
			level_d = target;
		end else if (ctl.step) begin
			level_d = level_q + delta[LVL_W-1:0];
		end else begin
			level_d = level_q;
		end
	end

	// Advance lane state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			quo_q   <= '0;
			rabs_q  <= '0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (ctl.en) begin
			level_q <= level_d;
			if (ctl.start) begin
				quo_q  <= new_quo;
				rabs_q <= new_rabs;
				neg_q  <= dneg;
			end
			// Advance the remainder share on a step, restart it on a fade start
			if (ctl.step) begin
				acc_q <= acc_n;
			end else if (ctl.start) begin
				acc_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### design/rlc_ctrl.sv
`default_nettype none

module rlc_ctrl import rlc_pkg::*; #(
	parameter int NUM_STEPS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [ACT_W-1:0]    action,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata,
	output lane_ctl_t           ctl,
	output logic                active_d,
	output logic                finished
);

	localparam int IDX_W = $clog2(NUM_STEPS + 2);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(15);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] ticks_q;
	logic [IDX_W-1:0]    idx_q;
	logic                active_q;

	logic [PERIOD_W-1:0] ticks_inc;
	logic [PERIOD_W-1:0] ticks_d;
	logic [IDX_W-1:0]    idx_cur;
	logic [IDX_W-1:0]    idx_d;
	logic                start;
	logic                set;
	logic                step;

	// Decode the action and decide whether a fade step is due
	always_comb begin
		ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + PERIOD_W'(1);
		ticks_d   = ticks_q;
		idx_cur   = idx_q;
		active_d  = active_q;
		start     = 1'b0;
		set       = 1'b0;
		step      = 1'b0;
		finished  = 1'b0;
		unique case (action)
			ACT_TICK: begin
				ticks_d = ticks_inc;
				step    = active_q && (ticks_inc > period_q);
			end
			ACT_START: begin
				start    = 1'b1;
				active_d = 1'b1;
				idx_cur  = IDX_W'(1);
				step     = ticks_q > period_q;
			end
			ACT_SET: begin
				set      = 1'b1;
				active_d = 1'b0;
			end
			default: begin
			end
		endcase
		idx_d = idx_cur;
		if (step) begin
			ticks_d = '0;
			idx_d   = idx_cur + IDX_W'(1);
			if (idx_d > IDX_W'(NUM_STEPS)) begin
				active_d = 1'b0;
				finished = 1'b1;
			end
		end
	end

	assign ctl = '{en: en, start: start, set: set, step: step};

	// Hold the step period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// Advance tick count, step index and fade flag per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= '0;
			idx_q    <= '0;
			active_q <= 1'b0;
		end else if (en) begin
			ticks_q  <= ticks_d;
			idx_q    <= idx_d;
			active_q <= active_d;
		end
	end

endmodule

`default_nettype wire

### design/rgb_linear_crossfade.sv
`default_nettype none

// Linear RGB cross-fade. Each item is a tick, a fade start toward a target
// color, or an immediate set; every item yields exactly one result holding
// the color after the item, a fading flag, and a finished flag on the item
// that took the last of NUM_STEPS steps. One item is accepted per cycle while
// no result waits, and its result is in the output register the next cycle;
// the rate is set by the combinational update of the three channel lanes,
// whose registered levels feed the next item. The user must write step_period
// (reset 15) through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
module rgb_linear_crossfade import rlc_pkg::*; #(
	parameter int NUM_STEPS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [PERIOD_W-1:0] cfg_wdata
);

	localparam int NUM_LANES = 3;

	logic                    accept;
	lane_ctl_t               ctl;
	logic                    active_d;
	logic                    finished;
	logic [LVL_W-1:0]        tgt     [NUM_LANES];
	logic [LVL_W-1:0]        level_d [NUM_LANES];
	logic                    out_valid_q;
	out_item_t               out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign tgt[0] = in_item.red_in;
	assign tgt[1] = in_item.green_in;
	assign tgt[2] = in_item.blue_in;

	rlc_ctrl #(
		.NUM_STEPS (NUM_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.action    (in_item.action),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.active_d  (active_d),
		.finished  (finished)
	);

	// One lane per color channel
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		rlc_lane #(
			.NUM_STEPS (NUM_STEPS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.target  (tgt[g]),
			.level_d (level_d[g])
		);
	end

	// Track output valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Merge lane levels and status into the result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= '{red_out:   level_d[0],
			           green_out: level_d[1],
			           blue_out:  level_d[2],
			           fading:    active_d,
			           finished:  finished};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

### design/rlc_checker.sv
`default_nettype none

module rlc_checker import rlc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Stall input only behind a stalled result
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in output register");

	// A finished fade is no longer fading
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.finished && out_item.fading))
		else $error("finished reported while fading");

	// An immediate set shows the target at once and cancels the fade
	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.action == ACT_SET |=>
			out_valid && !out_item.fading && !out_item.finished &&
			out_item.red_out == $past(in_item.red_in) &&
			out_item.green_out == $past(in_item.green_in) &&
			out_item.blue_out == $past(in_item.blue_in))
		else $error("immediate set not reflected in result");

endmodule

bind rgb_linear_crossfade rlc_checker u_rlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire

### sim/rgb_linear_crossfade_tb.sv
`default_nettype none

module rgb_linear_crossfade_tb;
	import rlc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FADE_STEPS = 32;
	localparam int TICK_SAT   = 65535;
	localparam int MAX_SHOWN  = 10;
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_item;
	logic                cfg_we = 1'b0;
	logic [PERIOD_W-1:0] cfg_wdata = '0;

	// Color predictor state
	logic [LVL_W-1:0] cur_level [3] = '{default: '0};
	int               step_quo [3]  = '{default: 0};
	int               step_rem [3]  = '{default: 0};
	int               step_num      = 0;
	int               tick_count    = 0;
	bit               fade_on       = 1'b0;
	int               fade_period   = 15;

	out_item_t color_expect [$];
	int        mismatches = 0;
	int        items_sent = 0;
	bit        stall_free = 1'b0;

	rgb_linear_crossfade #(.NUM_STEPS(FADE_STEPS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Take one fade step once the period has been exceeded; return 1 on the last step
	function automatic bit advance_fade();
		int c;
		int ar;
		int delta;
		if (!fade_on || tick_count <= fade_period)
			return 1'b0;
		tick_count = 0;
		for (c = 0; c < 3; c++) begin
			ar = (step_rem[c] < 0) ? -step_rem[c] : step_rem[c];
			delta = step_quo[c];
			// spread the remainder: one extra unit whenever the running share rolls over
			if ((step_num * ar) / FADE_STEPS > ((step_num - 1) * ar) / FADE_STEPS)
				delta += (step_quo[c] < 0 || step_rem[c] < 0) ? -1 : 1;
			cur_level[c] = LVL_W'(int'(cur_level[c]) + delta);
		end
		step_num = (step_num + 1) & 'h1FF;
		if (step_num > FADE_STEPS) begin
			fade_on = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the predictor by one item and return the color it should report
	function automatic out_item_t predict_color(in_item_t it);
		out_item_t        res;
		logic [LVL_W-1:0] tgt [3];
		bit               done;
		int               c;
		int               diff;
		tgt[0] = it.red_in;
		tgt[1] = it.green_in;
		tgt[2] = it.blue_in;
		done = 1'b0;
		case (it.action)
			ACT_TICK: begin
				if (tick_count < TICK_SAT)
					tick_count++;
				done = advance_fade();
			end
			ACT_START: begin
				for (c = 0; c < 3; c++) begin
					diff = int'(tgt[c]) - int'(cur_level[c]);
					step_quo[c] = diff / FADE_STEPS;
					step_rem[c] = diff % FADE_STEPS;
				end
				step_num = 1;
				fade_on = 1'b1;
				done = advance_fade();
			end
			ACT_SET: begin
				for (c = 0; c < 3; c++)
					cur_level[c] = tgt[c];
				fade_on = 1'b0;
			end
			default: ;
		endcase
		res.red_out   = cur_level[0];
		res.green_out = cur_level[1];
		res.blue_out  = cur_level[2];
		res.fading    = fade_on;
		res.finished  = done;
		return res;
	endfunction

	// Predict on every accepted item, then check every accepted result
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n) begin
			if (in_valid && in_ready)
				color_expect.push_back(predict_color(in_item));
			if (out_valid && out_ready) begin
				if (color_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result: rgb %0d %0d %0d",
							out_item.red_out, out_item.green_out, out_item.blue_out,
							" fading %0b finished %0b",
							out_item.fading, out_item.finished);
				end else begin
					exp_item = color_expect.pop_front();
					if (out_item.red_out !== exp_item.red_out ||
						out_item.green_out !== exp_item.green_out ||
						out_item.blue_out !== exp_item.blue_out ||
						out_item.fading !== exp_item.fading ||
						out_item.finished !== exp_item.finished) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected rgb %0d %0d %0d",
								exp_item.red_out, exp_item.green_out, exp_item.blue_out,
								" fading %0b finished %0b,",
								exp_item.fading, exp_item.finished,
								" got rgb %0d %0d %0d",
								out_item.red_out, out_item.green_out, out_item.blue_out,
								" fading %0b finished %0b",
								out_item.fading, out_item.finished);
					end
				end
			end
		end
	end

	// Stall the result side at random unless a stall-free stretch is running
	always @(posedge clk)
		out_ready <= stall_free || ($urandom_range(99) >= 30);

	function automatic in_item_t make_item(logic [ACT_W-1:0] act);
		in_item_t it;
		it.action   = act;
		it.red_in   = LVL_W'($urandom);
		it.green_in = LVL_W'($urandom);
		it.blue_in  = LVL_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t color_item(logic [ACT_W-1:0] act, int r, int g, int b);
		in_item_t it;
		it.action   = act;
		it.red_in   = LVL_W'(r);
		it.green_in = LVL_W'(g);
		it.blue_in  = LVL_W'(b);
		return it;
	endfunction

	// Offer one item, with random gaps before it, and hold it until accepted
	task automatic send_item(input in_item_t it);
		while (!stall_free && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (color_expect.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_period(input int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= PERIOD_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		fade_period = value;
	endtask

	// Reset period of 15: a step falls on the 16th tick, then a set cancels the fade
	task automatic test_reset_period();
		send_item(color_item(ACT_START, 255, 255, 255));
		repeat (16) send_item(make_item(ACT_TICK));
		send_item(color_item(ACT_SET, 0, 0, 0));
		drain();
	endtask

	// Period 0, extreme levels, a start that steps at once, a restart and an undefined action
	task automatic test_extremes();
		write_period(0);
		send_item(color_item(ACT_SET, 255, 0, 255));
		send_item(color_item(ACT_TICK, 0, 0, 0));
		send_item(color_item(ACT_START, 0, 255, 0));
		send_item(color_item(ACT_NOP, 255, 255, 255));
		send_item(color_item(ACT_TICK, 255, 255, 255));
		send_item(color_item(ACT_START, 0, 0, 0));
		send_item(color_item(ACT_TICK, 0, 0, 0));
		send_item(color_item(ACT_SET, 0, 0, 0));
		drain();
	endtask

	// One fade with random colors, sometimes cut short, with the odd stray item
	task automatic fade_sequence(input int period);
		int kind;
		int n_ticks;
		int i;
		kind = $urandom_range(9);
		if (kind < 2) begin
			send_item(make_item(ACT_W'($urandom_range(3))));
		end else begin
			if ($urandom_range(1))
				send_item(make_item(ACT_SET));
			send_item(make_item(ACT_START));
			n_ticks = (period + 1) * FADE_STEPS + $urandom_range(3);
			if (period > 3)
				n_ticks = $urandom_range(8, 48);
			if (kind == 2)
				n_ticks = $urandom_range(n_ticks);
			for (i = 0; i < n_ticks; i++) begin
				if ($urandom_range(39) == 0)
					send_item(make_item(ACT_W'($urandom_range(1, 3))));
				else
					send_item(make_item(ACT_TICK));
			end
		end
	endtask

	// Random fades over several periods, one phase without any idling
	task automatic test_random_fades();
		int periods [6];
		int p;
		int first;
		periods = '{0, 1, 0, 2, $urandom_range(3), $urandom_range(16, 65535)};
		for (p = 0; p < 6; p++) begin
			write_period(periods[p]);
			stall_free = (p == 2);
			first = items_sent;
			while (items_sent - first < ((p == 5) ? 40 : 65))
				fade_sequence(periods[p]);
			drain();
		end
		stall_free = 1'b0;
	endtask

	// Largest period stalls a fade, since the tick count can never exceed it; a
	// shorter period then lets the restarted fade step on the start item itself
	task automatic test_period_stall();
		write_period(TICK_SAT);
		stall_free = 1'b1;
		send_item(make_item(ACT_SET));
		send_item(make_item(ACT_START));
		repeat (20) send_item(make_item(ACT_TICK));
		drain();
		write_period(3);
		send_item(make_item(ACT_START));
		stall_free = 1'b0;
		repeat (4) send_item(make_item(ACT_TICK));
		send_item(make_item(ACT_SET));
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_period();
		test_extremes();
		test_random_fades();
		test_period_stall();
		if (mismatches == 0 && color_expect.size() == 0)
			$display("rgb_linear_crossfade_tb: PASS");
		else
			$display("rgb_linear_crossfade_tb: FAIL");
		$finish;
	end

	// Hard limit on the run
	initial begin
		#20_000_000;
		$display("rgb_linear_crossfade_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
design/rlc_pkg.sv
design/rlc_lane.sv
design/rlc_ctrl.sv
design/rgb_linear_crossfade.sv
design/rlc_checker.sv
sim/rgb_linear_crossfade_tb.sv
